// ----- design/pptc_pkg.sv -----
// ----------------------------------------------------------------------------
// pptc_pkg
// Shared types and constants for the primitive Pythagorean triple checker.
// ----------------------------------------------------------------------------
package pptc_pkg;

   // Width of each number field on the request port
   localparam int FIELD_WIDTH = 34;

   // Default internal operand width
   localparam int VALUE_WIDTH_DEF = 34;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] first_value;
      logic [FIELD_WIDTH-1:0] second_value;
      logic [FIELD_WIDTH-1:0] third_value;
   } req_type;

   typedef struct packed {
      logic is_triple;
      logic is_primitive;
   } rsp_type;

   // Completion of one item, from the sequencer to the result register
   typedef struct packed {
      logic    valid;
      rsp_type result;
   } done_type;

endpackage

// ----- design/pptc_add.sv -----
// ----------------------------------------------------------------------------
// pptc_add
// Shared add/subtract unit. Serves squaring steps, the sum-of-squares check
// and the GCD subtract/compare.
// ----------------------------------------------------------------------------
module pptc_add #(
   parameter int WIDTH = 69
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             sub,
   output logic [WIDTH-1:0] sum
);

   logic [WIDTH-1:0] b_eff;

   assign b_eff = sub ? ~op_b : op_b;
   assign sum   = op_a + b_eff + WIDTH'(sub);

endmodule

// ----- design/pptc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pptc_ctrl
// Sequencer and operand registers. Squares the three values by shift-add,
// checks the three hypotenuse candidates, then, for a triple, runs up to three
// binary GCDs, all through the shared adder.
// ----------------------------------------------------------------------------
module pptc_ctrl #(
   parameter int VALUE_WIDTH = 34
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  pptc_pkg::req_type           req_item,
   output logic                        busy,
   output pptc_pkg::done_type          done,
   output logic [2*VALUE_WIDTH:0]      add_a,
   output logic [2*VALUE_WIDTH:0]      add_b,
   output logic                        add_sub,
   input  logic [2*VALUE_WIDTH:0]      add_sum
);
   import pptc_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int SW = 2 * VALUE_WIDTH;
   localparam int AW = 2 * VALUE_WIDTH + 1;
   localparam int BW = $clog2(VALUE_WIDTH);
   localparam int EW = FIELD_WIDTH + VALUE_WIDTH;
   localparam logic [BW-1:0] BIT_TOP = BW'(VALUE_WIDTH - 1);
   localparam logic [1:0]    IDX_LAST = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQR,
      ST_CHK,
      ST_GLOAD,
      ST_GSTEP
   } state_type;

   state_type         state_ff, state_in;
   logic [W-1:0]      val_ff [3];
   logic [W-1:0]      val_in [3];
   logic [SW-1:0]     sq_ff [3];
   logic [SW-1:0]     sq_in [3];
   logic [SW-1:0]     acc_ff, acc_in;
   logic [BW-1:0]     bit_ff, bit_in;
   logic [1:0]        idx_ff, idx_in;
   logic              tri_ff, tri_in;
   logic [W-1:0]      u_ff, u_in;
   logic [W-1:0]      v_ff, v_in;

   logic [EW-1:0]     ext0, ext1, ext2;
   logic [W-1:0]      x_cur;
   logic [W-1:0]      big, s1, s2;
   logic [SW-1:0]     qb, q1, q2;
   logic              hit;
   logic              tri_now;
   logic              fin;
   logic              ok;

   assign ext0 = {{VALUE_WIDTH{1'b0}}, req_item.first_value};
   assign ext1 = {{VALUE_WIDTH{1'b0}}, req_item.second_value};
   assign ext2 = {{VALUE_WIDTH{1'b0}}, req_item.third_value};

   assign busy = (state_ff != ST_IDLE);

   // operand selection by item index
   always_comb begin
      case (idx_ff)
         2'd0: begin
            x_cur = val_ff[0];
            big = val_ff[0]; s1 = val_ff[1]; s2 = val_ff[2];
            qb = sq_ff[0];   q1 = sq_ff[1];  q2 = sq_ff[2];
         end
         2'd1: begin
            x_cur = val_ff[1];
            big = val_ff[1]; s1 = val_ff[0]; s2 = val_ff[2];
            qb = sq_ff[1];   q1 = sq_ff[0];  q2 = sq_ff[2];
         end
         default: begin
            x_cur = val_ff[2];
            big = val_ff[2]; s1 = val_ff[0]; s2 = val_ff[1];
            qb = sq_ff[2];   q1 = sq_ff[0];  q2 = sq_ff[1];
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      sq_in    = sq_ff;
      acc_in   = acc_ff;
      bit_in   = bit_ff;
      idx_in   = idx_ff;
      tri_in   = tri_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      add_a    = '0;
      add_b    = '0;
      add_sub  = 1'b0;
      done     = '0;
      hit      = 1'b0;
      tri_now  = tri_ff;
      fin      = 1'b0;
      ok       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               val_in[0] = ext0[W-1:0];
               val_in[1] = ext1[W-1:0];
               val_in[2] = ext2[W-1:0];
               acc_in    = '0;
               bit_in    = BIT_TOP;
               idx_in    = 2'd0;
               tri_in    = 1'b0;
               state_in  = ST_SQR;
            end
         end

         // acc = 2*acc + (x[bit] ? x : 0), MSB first
         ST_SQR: begin
            add_a  = {1'b0, acc_ff[SW-2:0], 1'b0};
            add_b  = x_cur[bit_ff] ? AW'(x_cur) : '0;
            acc_in = add_sum[SW-1:0];
            if (bit_ff == '0) begin
               case (idx_ff)
                  2'd0:    sq_in[0] = add_sum[SW-1:0];
                  2'd1:    sq_in[1] = add_sum[SW-1:0];
                  default: sq_in[2] = add_sum[SW-1:0];
               endcase
               acc_in = '0;
               bit_in = BIT_TOP;
               if (idx_ff == IDX_LAST) begin
                  idx_in   = 2'd0;
                  state_in = ST_CHK;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end else begin
               bit_in = bit_ff - BW'(1);
            end
         end

         // candidate idx as the largest: big^2 == s1^2 + s2^2 (sum keeps carry)
         ST_CHK: begin
            add_a   = {1'b0, q1};
            add_b   = {1'b0, q2};
            hit     = (big >= s1) && (big >= s2) && (add_sum == {1'b0, qb});
            tri_now = tri_ff | hit;
            tri_in  = tri_now;
            if (idx_ff == IDX_LAST) begin
               idx_in = 2'd0;
               if (tri_now) begin
                  state_in = ST_GLOAD;
               end else begin
                  done.valid = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end

         // pairs: (first, second), (second, third), (first, third)
         ST_GLOAD: begin
            case (idx_ff)
               2'd0: begin
                  u_in = val_ff[0]; v_in = val_ff[1];
               end
               2'd1: begin
                  u_in = val_ff[1]; v_in = val_ff[2];
               end
               default: begin
                  u_in = val_ff[0]; v_in = val_ff[2];
               end
            endcase
            state_in = ST_GSTEP;
         end

         // binary GCD step, only deciding whether the GCD is one
         ST_GSTEP: begin
            add_a   = AW'(u_ff);
            add_b   = AW'(v_ff);
            add_sub = 1'b1;
            if (u_ff == '0) begin
               fin = 1'b1;
               ok  = (v_ff == W'(1));
            end else if (v_ff == '0) begin
               fin = 1'b1;
               ok  = (u_ff == W'(1));
            end else if (!u_ff[0] && !v_ff[0]) begin
               fin = 1'b1;
               ok  = 1'b0;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!add_sum[AW-1]) begin
               u_in = add_sum[W-1:0];
            end else begin
               // u < v: swap so the next step subtracts the other way
               u_in = v_ff;
               v_in = u_ff;
            end

            if (fin) begin
               if (!ok) begin
                  done.valid            = 1'b1;
                  done.result.is_triple = 1'b1;
                  state_in              = ST_IDLE;
               end else if (idx_ff == IDX_LAST) begin
                  done.valid               = 1'b1;
                  done.result.is_triple    = 1'b1;
                  done.result.is_primitive = 1'b1;
                  state_in                 = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_GLOAD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      val_ff <= val_in;
      sq_ff  <= sq_in;
      acc_ff <= acc_in;
      bit_ff <= bit_in;
      idx_ff <= idx_in;
      tri_ff <= tri_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
   end

endmodule

// ----- design/primitive_pythagorean_triple_check_top.sv -----
// ----------------------------------------------------------------------------
// primitive_pythagorean_triple_check_top
// A request is a transfer at a clock edge with start high and busy low; the
// three values are masked to VALUE_WIDTH bits. Exactly one result follows per
// request, on rsp_item with rsp_valid high for a single cycle; the receiver
// cannot stall it. The work, in order: shift-add squaring of the three values,
// a check of the three hypotenuse candidates, then, only for a triple, up to
// three binary GCD runs, each a load step followed by GCD steps, all on the one
// shared adder; the runs stop at the first pair whose GCD is not one. busy
// stays high for the whole computation and drops in the cycle the result is
// presented.
// ----------------------------------------------------------------------------
module primitive_pythagorean_triple_check_top #(
   parameter int VALUE_WIDTH = pptc_pkg::VALUE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  pptc_pkg::req_type  req_item,
   output logic               rsp_valid,
   output pptc_pkg::rsp_type  rsp_item
);
   import pptc_pkg::*;

   localparam int AW = 2 * VALUE_WIDTH + 1;

   logic              load;
   logic              ctrl_busy;
   done_type          done;
   logic [AW-1:0]     add_a, add_b, add_sum;
   logic              add_sub;
   logic              rsp_valid_ff;
   rsp_type           rsp_item_ff;

   assign load = start && !ctrl_busy;

   pptc_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .req_item (req_item),
      .busy     (ctrl_busy),
      .done     (done),
      .add_a    (add_a),
      .add_b    (add_b),
      .add_sub  (add_sub),
      .add_sum  (add_sum)
   );

   pptc_add #(
      .WIDTH (AW)
   ) u_add (
      .op_a (add_a),
      .op_b (add_b),
      .sub  (add_sub),
      .sum  (add_sum)
   );

   // result register: one-cycle strobe per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done.valid;
      end
      if (done.valid) begin
         rsp_item_ff <= done.result;
      end
   end

   assign busy      = ctrl_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ----- dv/pptc_result_monitor.sv -----
// ----------------------------------------------------------------------------
// pptc_result_monitor
// Watches the request and result channels of the primitive Pythagorean
// triple checker. Every accepted request gets its two flags predicted from
// exact wide squares and remainder-loop GCDs. Each result strobe is compared
// with the oldest prediction, and mismatches are counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pptc_result_monitor #(
   parameter int VALUE_WIDTH = pptc_pkg::VALUE_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  pptc_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  pptc_pkg::rsp_type rsp_item,
   output int                mismatch_count,
   output int                pending_count
);
   import pptc_pkg::*;

   typedef struct {
      req_type item;
      rsp_type flags;
   } flag_entry_type;

   flag_entry_type expected_flags[$];
   int             result_index;

   function automatic logic [63:0] operand_mask();
      return (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
   endfunction

   // big^2 == s^2 + t^2, evaluated at full width so nothing is lost
   function automatic bit squares_balance(logic [63:0] big, logic [63:0] s,
                                          logic [63:0] t);
      logic [128:0] lhs;
      logic [128:0] rhs;
      lhs = 129'(big) * 129'(big);
      rhs = 129'(s) * 129'(s) + 129'(t) * 129'(t);
      return lhs == rhs;
   endfunction

   // gcd(0, x) = x, so gcd(0, 0) = 0
   function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      while (y != 64'd0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic rsp_type predict_triple_flags(req_type item);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      rsp_type     flags;
      a = 64'(item.first_value) & operand_mask();
      b = 64'(item.second_value) & operand_mask();
      c = 64'(item.third_value) & operand_mask();
      flags.is_triple = 1'b0;
      if (a >= b && a >= c && squares_balance(a, b, c)) flags.is_triple = 1'b1;
      if (b >= a && b >= c && squares_balance(b, a, c)) flags.is_triple = 1'b1;
      if (c >= a && c >= b && squares_balance(c, a, b)) flags.is_triple = 1'b1;
      flags.is_primitive = flags.is_triple
                           && euclid_gcd(a, b) == 64'd1
                           && euclid_gcd(b, c) == 64'd1
                           && euclid_gcd(a, c) == 64'd1;
      return flags;
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      result_index   = 0;
   end

   always @(posedge clock) begin : watch_channels
      flag_entry_type head;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_flags.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d with no request pending: triple=%b primitive=%b",
                           result_index, rsp_item.is_triple, rsp_item.is_primitive);
            end else begin
               head = expected_flags.pop_front();
               if (rsp_item.is_triple !== head.flags.is_triple
                   || rsp_item.is_primitive !== head.flags.is_primitive) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"result %0d for (%0d, %0d, %0d): expected triple=%b ",
                               "primitive=%b, got triple=%b primitive=%b"},
                              result_index, head.item.first_value,
                              head.item.second_value, head.item.third_value,
                              head.flags.is_triple, head.flags.is_primitive,
                              rsp_item.is_triple, rsp_item.is_primitive);
               end
            end
            result_index++;
         end
         // a request transfer
         if (start && !busy)
            expected_flags.push_back('{req_item, predict_triple_flags(req_item)});
      end
      pending_count = expected_flags.size();
   end

endmodule

// ----- dv/primitive_pythagorean_triple_check_top_tb.sv -----
// ----------------------------------------------------------------------------
// primitive_pythagorean_triple_check_top_tb
// Drives the triple checker with directed triples, near misses, zero and
// full-scale operands, then random Euclid-generated triples mixed with noise,
// in bursts with random gaps. A separate monitor predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module primitive_pythagorean_triple_check_top_tb;
   import pptc_pkg::*;

   localparam int               VALUE_WIDTH   = VALUE_WIDTH_DEF;
   localparam longint unsigned  NOMINAL_MAX   = 64'd9999999999;
   localparam longint unsigned  FIELD_MAX     = (64'd1 << FIELD_WIDTH) - 64'd1;
   localparam int unsigned      M_LIMIT       = 92681;   // m^2 + n^2 stays in 34 bits
   localparam int               RANDOM_ITEMS  = 1030;
   localparam int               SETTLE_CYCLES = 16 * VALUE_WIDTH + 20;
   localparam int               CYCLE_LIMIT   = 3_000_000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      mismatch_count;
   int      pending_count;
   int      cycle_count;

   req_type stimulus_q[$];
   int      directed_count;

   primitive_pythagorean_triple_check_top #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   pptc_result_monitor #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) result_monitor (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic req_type make_item(longint unsigned x, longint unsigned y,
                                         longint unsigned z);
      req_type item;
      item.first_value  = x[FIELD_WIDTH-1:0];
      item.second_value = y[FIELD_WIDTH-1:0];
      item.third_value  = z[FIELD_WIDTH-1:0];
      return item;
   endfunction

   // Euclid's formula, legs first, hypotenuse last
   function automatic req_type euclid_triple(longint unsigned m, longint unsigned n,
                                             longint unsigned k);
      return make_item(k * (m * m - n * n), k * 2 * m * n, k * (m * m + n * n));
   endfunction

   function automatic longint unsigned random_bits(int nbits);
      longint unsigned v;
      v = {$urandom, $urandom};
      return (nbits >= 64) ? v : (v & ((64'd1 << nbits) - 64'd1));
   endfunction

   function automatic req_type shuffled(req_type item);
      longint unsigned a;
      longint unsigned b;
      longint unsigned c;
      a = item.first_value;
      b = item.second_value;
      c = item.third_value;
      case ($urandom_range(5))
         0: return make_item(a, b, c);
         1: return make_item(a, c, b);
         2: return make_item(b, a, c);
         3: return make_item(b, c, a);
         4: return make_item(c, a, b);
         default: return make_item(c, b, a);
      endcase
   endfunction

   // random m > n, mostly unscaled so primitive and scaled triples both show up
   function automatic req_type random_triple(int unsigned m_max);
      longint unsigned m;
      longint unsigned n;
      longint unsigned k;
      longint unsigned k_max;
      m = $urandom_range(m_max, 2);
      n = $urandom_range(int'(m) - 1, 1);
      k_max = FIELD_MAX / (m * m + n * n);
      k = 1;
      if ($urandom_range(2) == 0 && k_max > 1)
         k = $urandom_range((k_max > 500) ? 500 : int'(k_max), 2);
      return shuffled(euclid_triple(m, n, k));
   endfunction

   function automatic req_type near_miss(req_type item);
      int pick;
      pick = $urandom_range(2);
      if ($urandom_range(1) == 0) begin
         if (pick == 0) item.first_value++;
         else if (pick == 1) item.second_value++;
         else item.third_value++;
      end else begin
         if (pick == 0) item.first_value--;
         else if (pick == 1) item.second_value--;
         else item.third_value--;
      end
      return item;
   endfunction

   function automatic req_type random_item();
      int              pick;
      longint unsigned x;
      pick = $urandom_range(99);
      if (pick < 35) return random_triple(60);
      if (pick < 50) return random_triple(M_LIMIT);
      if (pick < 63) return near_miss(random_triple(($urandom_range(3) == 0) ? M_LIMIT : 40));
      if (pick < 76) return make_item(random_bits(64), random_bits(64), random_bits(64));
      if (pick < 86)
         return make_item($urandom_range(30), $urandom_range(30), $urandom_range(30));
      if (pick < 92) begin
         // zero leg: hypotenuse equals the other leg
         x = ($urandom_range(1) == 0) ? $urandom_range(40) : random_bits(64);
         return shuffled(make_item(64'd0, x, x));
      end
      return make_item(random_bits($urandom_range(34, 1)), random_bits($urandom_range(34, 1)),
                       random_bits($urandom_range(34, 1)));
   endfunction

   initial begin
      int burst_len;
      int gap_len;
      int idx;
      int j;

      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;

      stimulus_q.push_back(make_item(3, 4, 5));
      stimulus_q.push_back(make_item(5, 3, 4));
      stimulus_q.push_back(make_item(4, 5, 3));
      stimulus_q.push_back(make_item(6, 8, 10));
      stimulus_q.push_back(make_item(5, 12, 13));
      stimulus_q.push_back(make_item(17, 15, 8));
      stimulus_q.push_back(make_item(20, 21, 29));
      stimulus_q.push_back(make_item(9, 12, 15));
      stimulus_q.push_back(make_item(3, 4, 6));
      stimulus_q.push_back(make_item(1, 1, 1));
      stimulus_q.push_back(make_item(2, 2, 2));
      stimulus_q.push_back(make_item(0, 0, 0));
      stimulus_q.push_back(make_item(0, 1, 1));
      stimulus_q.push_back(make_item(0, 5, 5));
      stimulus_q.push_back(make_item(5, 0, 5));
      stimulus_q.push_back(make_item(FIELD_MAX, 0, FIELD_MAX));
      stimulus_q.push_back(make_item(0, 1, FIELD_MAX));
      stimulus_q.push_back(make_item(NOMINAL_MAX, NOMINAL_MAX, NOMINAL_MAX));
      stimulus_q.push_back(make_item(FIELD_MAX, FIELD_MAX, FIELD_MAX));
      stimulus_q.push_back(make_item(1, NOMINAL_MAX, 1));
      stimulus_q.push_back(euclid_triple(92000, 1, 1));
      stimulus_q.push_back(euclid_triple(M_LIMIT, M_LIMIT - 1, 1));
      stimulus_q.push_back(near_miss(euclid_triple(M_LIMIT, M_LIMIT - 1, 1)));
      stimulus_q.push_back(euclid_triple(2, 1, FIELD_MAX / 5));
      directed_count = stimulus_q.size();
      repeat (RANDOM_ITEMS) stimulus_q.push_back(random_item());

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idx = 0;
      while (idx < stimulus_q.size()) begin
         burst_len = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
         for (j = 0; j < burst_len && idx < stimulus_q.size(); j++) begin
            @(negedge clock);
            start    <= 1'b1;
            req_item <= stimulus_q[idx];
            do @(posedge clock); while (busy);
            idx++;
            if (idx == directed_count) break;
         end
         @(negedge clock);
         start    <= 1'b0;
         req_item <= make_item(random_bits(64), random_bits(64), random_bits(64));
         // let the block drain completely now and then
         if (idx == directed_count || $urandom_range(19) == 0)
            wait (pending_count == 0);
         gap_len = ($urandom_range(5) == 0) ? $urandom_range(40, 4) : $urandom_range(3);
         repeat (gap_len) @(negedge clock);
      end

      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
